[rtl/clws_pkg.sv]
// Shared types, constants and elaboration-time constant functions for the
// cubed-logistic wavelength sampler. No dependencies.
`default_nettype none
package clws_pkg;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd1;

	localparam logic [31:0] CENTER_RST = 32'd121567000;
	localparam logic [23:0] SCALE_RST = 24'd40522;

	// |s| limit in Q3.28 (3.6 truncated)
	localparam logic [30:0] OFFSET_LIMIT = 31'd966367641;

	// ln(N) in unsigned Q5.56
	localparam int LN_W = 61;

	// restoring divider for y = (N-P)/(N+P) in Q0.62
	localparam int DIV_STEPS = 62;
	localparam int DIV_PER_STG = 4;
	localparam int DIV_STG = (DIV_STEPS + DIV_PER_STG - 1) / DIV_PER_STG;

	// atanh series terms; y < 1/3 makes every later term zero
	localparam int TERMS = 20;

	// encode + divider + y^2 (two) + two per term + two to finish
	localparam int LN_LAT = DIV_STG + 2 * TERMS + 5;

	localparam int CBRT_BITS = 31;

	// magnitude, cube root bits, rounding, scale multiply, output
	localparam int TOT_LAT = LN_LAT + CBRT_BITS + 4;

	// floor(num / den), bit by bit; only evaluated at elaboration
	function automatic logic [63:0] cdiv(input logic [127:0] num, input logic [63:0] den);
		logic [127:0] rem;
		logic [127:0] quo;
		int i;
		rem = '0;
		quo = '0;
		for (i = 127; i >= 0; i--) begin
			rem = {rem[126:0], num[i]};
			quo = {quo[126:0], 1'b0};
			if (rem >= {64'd0, den}) begin
				rem = rem - {64'd0, den};
				quo[0] = 1'b1;
			end
		end
		return quo[63:0];
	endfunction

	// reciprocal for an exact truncating divide of a Q0.62 value by d
	function automatic logic [63:0] recip_m(input int unsigned d);
		int unsigned l;
		logic [127:0] num;
		l = $clog2(d);
		num = (128'd1 << (62 + l)) + 128'(d) - 128'd1;
		return cdiv(num, 64'(d));
	endfunction

	function automatic int recip_s(input int unsigned d);
		return 62 + $clog2(d);
	endfunction

	// ln2 = 2*atanh(1/3), same truncations as the datapath
	function automatic logic [63:0] calc_ln2();
		logic [127:0] y;
		logic [127:0] y2;
		logic [127:0] p;
		logic [127:0] sum;
		int j;
		y = {64'd0, cdiv(128'd1 << 62, 64'd3)};
		y2 = (y * y) >> 62;
		p = y;
		sum = '0;
		for (j = 0; j < 32; j++) begin
			sum = sum + {64'd0, cdiv(p, 64'(2 * j + 1))};
			p = (p * y2) >> 62;
		end
		return 64'((sum + 128'd16) >> 5);
	endfunction

	localparam logic [63:0] LN2_Q56 = calc_ln2();

endpackage
`default_nettype wire

[rtl/clws_ln.sv]
// Pipelined natural log of a 32-bit integer, Q5.56 result.
// Uses clws_pkg for latency, widths and constants.
`default_nettype none
module clws_ln (
	input  wire logic                     clk,
	input  wire logic [31:0]              n,
	output logic      [clws_pkg::LN_W-1:0] ln_q56
);

	localparam int DSTG = clws_pkg::DIV_STG;
	localparam int NT = clws_pkg::TERMS;
	localparam int LN_W_C = clws_pkg::LN_W;

	// exponent and operands of y = (N-P)/(N+P)
	logic [4:0]  enc_e;
	logic [30:0] enc_num;
	logic [32:0] enc_den;

	always_comb begin
		enc_e = '0;
		for (int i = 1; i < 32; i++) begin
			if (n[i]) begin
				enc_e = 5'(i);
			end
		end
		enc_num = 31'(n & ~(32'd1 << enc_e));
		enc_den = {1'b0, n} + (33'd1 << enc_e);
	end

	logic [33:0] div_rem_s [DSTG+1];
	logic [32:0] div_den_s [DSTG+1];
	logic [61:0] div_q_s   [DSTG+1];
	logic [4:0]  div_e_s   [DSTG+1];

	always_ff @(posedge clk) begin
		div_rem_s[0] <= {3'd0, enc_num};
		div_den_s[0] <= enc_den;
		div_q_s[0]   <= '0;
		div_e_s[0]   <= enc_e;
	end

	for (genvar g = 0; g < DSTG; g++) begin : g_div
		logic [33:0] rem_c;
		logic [61:0] q_c;

		always_comb begin
			rem_c = div_rem_s[g];
			q_c = div_q_s[g];
			for (int t = 0; t < clws_pkg::DIV_PER_STG; t++) begin
				if (g * clws_pkg::DIV_PER_STG + t < clws_pkg::DIV_STEPS) begin
					rem_c = {rem_c[32:0], 1'b0};
					q_c = {q_c[60:0], 1'b0};
					if (rem_c >= {1'b0, div_den_s[g]}) begin
						rem_c = rem_c - {1'b0, div_den_s[g]};
						q_c[0] = 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			div_rem_s[g+1] <= rem_c;
			div_den_s[g+1] <= div_den_s[g];
			div_q_s[g+1]   <= q_c;
			div_e_s[g+1]   <= div_e_s[g];
		end
	end

	// y^2, split into 31-bit halves
	logic [61:0] sq_ll_s, sq_lh_s, sq_hh_s, sq_y_s;
	logic [4:0]  sq_e_s;
	logic [30:0] y_lo, y_hi;

	assign y_lo = div_q_s[DSTG][30:0];
	assign y_hi = div_q_s[DSTG][61:31];

	always_ff @(posedge clk) begin
		sq_ll_s <= 62'(y_lo) * 62'(y_lo);
		sq_lh_s <= 62'(y_lo) * 62'(y_hi);
		sq_hh_s <= 62'(y_hi) * 62'(y_hi);
		sq_y_s  <= div_q_s[DSTG];
		sq_e_s  <= div_e_s[DSTG];
	end

	logic [123:0] sq_full;
	assign sq_full = {sq_hh_s, 62'd0} + {30'd0, sq_lh_s, 32'd0} + {62'd0, sq_ll_s};

	logic [61:0] ser_p_s   [NT+1];
	logic [61:0] ser_y2_s  [NT+1];
	logic [61:0] ser_sum_s [NT+1];
	logic [61:0] ser_q_s   [NT+1];
	logic [4:0]  ser_e_s   [NT+1];

	always_ff @(posedge clk) begin
		ser_p_s[0]   <= sq_y_s;
		ser_y2_s[0]  <= sq_full[123:62];
		ser_sum_s[0] <= '0;
		ser_q_s[0]   <= '0;
		ser_e_s[0]   <= sq_e_s;
	end

	// term j: next power p*y^2 and p/(2j+1) by reciprocal multiply
	for (genvar j = 0; j < NT; j++) begin : g_term
		localparam logic [63:0] MJ = clws_pkg::recip_m(2 * j + 1);
		localparam int SJ = clws_pkg::recip_s(2 * j + 1);

		logic [30:0] p_lo, p_hi, y2_lo, y2_hi;
		logic [61:0] mp_ll_s, mp_lh_s, mp_hl_s, mp_hh_s;
		logic [52:0] dp_s [6];
		logic [61:0] sum_s, y2_s;
		logic [4:0]  e_s;
		logic [123:0] pw_full;
		logic [127:0] dv_full;

		assign p_lo = ser_p_s[j][30:0];
		assign p_hi = ser_p_s[j][61:31];
		assign y2_lo = ser_y2_s[j][30:0];
		assign y2_hi = ser_y2_s[j][61:31];

		always_ff @(posedge clk) begin
			mp_ll_s <= 62'(p_lo) * 62'(y2_lo);
			mp_lh_s <= 62'(p_lo) * 62'(y2_hi);
			mp_hl_s <= 62'(p_hi) * 62'(y2_lo);
			mp_hh_s <= 62'(p_hi) * 62'(y2_hi);
			dp_s[0] <= 53'(p_lo) * 53'(MJ[21:0]);
			dp_s[1] <= 53'(p_lo) * 53'(MJ[43:22]);
			dp_s[2] <= 53'(p_lo) * 53'(MJ[63:44]);
			dp_s[3] <= 53'(p_hi) * 53'(MJ[21:0]);
			dp_s[4] <= 53'(p_hi) * 53'(MJ[43:22]);
			dp_s[5] <= 53'(p_hi) * 53'(MJ[63:44]);
			sum_s   <= ser_sum_s[j] + ser_q_s[j];
			y2_s    <= ser_y2_s[j];
			e_s     <= ser_e_s[j];
		end

		assign pw_full = {mp_hh_s, 62'd0} + {31'd0, mp_lh_s, 31'd0}
			+ {31'd0, mp_hl_s, 31'd0} + {62'd0, mp_ll_s};
		assign dv_full = {75'd0, dp_s[0]} + ({75'd0, dp_s[1]} << 22)
			+ ({75'd0, dp_s[2]} << 44) + ({75'd0, dp_s[3]} << 31)
			+ ({75'd0, dp_s[4]} << 53) + ({75'd0, dp_s[5]} << 75);

		always_ff @(posedge clk) begin
			ser_p_s[j+1]   <= pw_full[123:62];
			ser_q_s[j+1]   <= 62'(dv_full >> SJ);
			ser_sum_s[j+1] <= sum_s;
			ser_y2_s[j+1]  <= y2_s;
			ser_e_s[j+1]   <= e_s;
		end
	end

	logic [61:0]         fin_sum_s;
	logic [LN_W_C-1:0]   fin_eln_s;

	always_ff @(posedge clk) begin
		fin_sum_s <= ser_sum_s[NT] + ser_q_s[NT];
		fin_eln_s <= LN_W_C'(ser_e_s[NT]) * clws_pkg::LN2_Q56[LN_W_C-1:0];
	end

	logic [62:0] fin_rnd;
	assign fin_rnd = ({1'b0, fin_sum_s} + 63'd16) >> 5;

	always_ff @(posedge clk) begin
		ln_q56 <= fin_eln_s + fin_rnd[LN_W_C-1:0];
	end

endmodule
`default_nettype wire

[rtl/cubed_logistic_wavelength_sampler_top.sv]
// Cubed-logistic wavelength sampler, top level: log lanes, cube root,
// scaling and config registers. Uses clws_pkg and clws_ln.
`default_nettype none
// Usage:
//   Input: drive uniform_word with start high; the word is taken at any
//   rising edge with start high and busy low. busy stays low, so one word
//   can be taken every cycle.
//   Output: done pulses for one cycle with wavelength_fm and
//   offset_scale_units; the receiver cannot hold results off. A word of
//   zero, or a sample beyond 3.6 scale units, gives no pulse; the caller
//   then sends a fresh word.
//   Depth: clws_pkg::TOT_LAT gives the pipeline depth from the edge that
//   takes a word to done. It is set by the 62-step divider (4 steps a stage),
//   two stages per atanh term over 20 terms and one stage per cube-root bit
//   over 31 bits. Throughput is one word per cycle.
//   Config: cfg_index/cfg_data written on cfg_valid with cfg_ready (always
//   high); index 0 center, 1 scale, others ignored. Write only while idle.
//   Reset: arst_n clears the valid pipeline and restores both registers.
module cubed_logistic_wavelength_sampler_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [31:0]                     uniform_word,
	output logic                                 done,
	output logic [31:0]                          wavelength_fm,
	output logic signed [30:0]                   offset_scale_units,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [clws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                     cfg_data
);

	localparam int LNW = clws_pkg::LN_W;
	localparam int LLAT = clws_pkg::LN_LAT;
	localparam int NB = clws_pkg::CBRT_BITS;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	logic [31:0] center_q;
	logic [23:0] scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= clws_pkg::CENTER_RST;
			scale_q <= clws_pkg::SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				clws_pkg::REG_CENTER: center_q <= cfg_data;
				clws_pkg::REG_SCALE:  scale_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	logic take;
	assign take = start && !busy && (uniform_word != 32'd0);

	// ln(k) and ln(2^32 - k)
	logic [31:0]    word_b;
	logic [LNW-1:0] ln_a, ln_b;
	assign word_b = 32'd0 - uniform_word;

	clws_ln u_ln_a (.clk(clk), .n(uniform_word), .ln_q56(ln_a));
	clws_ln u_ln_b (.clk(clk), .n(word_b), .ln_q56(ln_b));

	logic [LLAT-1:0] ln_vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ln_vld_s <= '0;
		end else begin
			ln_vld_s <= {ln_vld_s[LLAT-2:0], take};
		end
	end

	// cube root state: r, r^2, r^3, built one bit a stage from the top
	logic [30:0]    cb_r_s   [NB+1];
	logic [61:0]    cb_r2_s  [NB+1];
	logic [92:0]    cb_r3_s  [NB+1];
	logic [LNW-1:0] cb_m_s   [NB+1];
	logic           cb_neg_s [NB+1];
	logic           cb_vld_s [NB+1];

	logic ln_neg;
	assign ln_neg = ln_a < ln_b;

	always_ff @(posedge clk) begin
		cb_r_s[0]   <= '0;
		cb_r2_s[0]  <= '0;
		cb_r3_s[0]  <= '0;
		cb_m_s[0]   <= ln_neg ? (ln_b - ln_a) : (ln_a - ln_b);
		cb_neg_s[0] <= ln_neg;
	end

	for (genvar i = 0; i < NB; i++) begin : g_cbrt
		localparam int B = NB - 1 - i;
		logic [95:0] cube_c;
		logic [95:0] lim_c;
		logic        fit_c;

		always_comb begin
			cube_c = 96'(cb_r3_s[i]) + (96'(cb_r2_s[i]) << (B + 1))
				+ (96'(cb_r2_s[i]) << B) + (96'(cb_r_s[i]) << (2 * B + 1))
				+ (96'(cb_r_s[i]) << (2 * B)) + (96'd1 << (3 * B));
			lim_c = 96'(cb_m_s[i]) << 28;
			fit_c = cube_c <= lim_c;
		end

		always_ff @(posedge clk) begin
			cb_m_s[i+1]   <= cb_m_s[i];
			cb_neg_s[i+1] <= cb_neg_s[i];
			if (fit_c) begin
				cb_r_s[i+1]  <= cb_r_s[i] | (31'd1 << B);
				cb_r2_s[i+1] <= cb_r2_s[i] + (62'(cb_r_s[i]) << (B + 1)) + (62'd1 << (2 * B));
				cb_r3_s[i+1] <= cube_c[92:0];
			end else begin
				cb_r_s[i+1]  <= cb_r_s[i];
				cb_r2_s[i+1] <= cb_r2_s[i];
				cb_r3_s[i+1] <= cb_r3_s[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NB; i++) begin
				cb_vld_s[i] <= 1'b0;
			end
		end else begin
			cb_vld_s[0] <= ln_vld_s[LLAT-1];
			for (int i = 0; i < NB; i++) begin
				cb_vld_s[i+1] <= cb_vld_s[i];
			end
		end
	end

	// round to nearest: (2r+1)^3 <= 8 * m * 2^28 means r + 1
	logic [96:0] half_cube;
	logic [96:0] half_lim;
	assign half_cube = (97'(cb_r3_s[NB]) << 3) + (97'(cb_r2_s[NB]) << 3)
		+ (97'(cb_r2_s[NB]) << 2) + (97'(cb_r_s[NB]) << 2)
		+ (97'(cb_r_s[NB]) << 1) + 97'd1;
	assign half_lim = 97'(cb_m_s[NB]) << 31;

	logic [30:0] rnd_r_s;
	logic        rnd_neg_s;
	logic        rnd_vld_s;

	always_ff @(posedge clk) begin
		rnd_r_s <= cb_r_s[NB] + ((half_cube <= half_lim) ? 31'd1 : 31'd0);
		rnd_neg_s <= cb_neg_s[NB];
	end

	logic [54:0] mul_prod_s;
	logic [30:0] mul_r_s;
	logic        mul_neg_s;
	logic        mul_vld_s;

	always_ff @(posedge clk) begin
		mul_prod_s <= 55'(rnd_r_s) * 55'(scale_q);
		mul_r_s <= rnd_r_s;
		mul_neg_s <= rnd_neg_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_vld_s <= 1'b0;
			mul_vld_s <= 1'b0;
		end else begin
			rnd_vld_s <= cb_vld_s[NB];
			mul_vld_s <= rnd_vld_s && (rnd_r_s <= clws_pkg::OFFSET_LIMIT);
		end
	end

	// center*2^28 + s*scale + 2^27, then saturate
	logic signed [63:0] wl_sum;
	logic signed [63:0] wl_off;
	logic [31:0]        wl_sat;

	always_comb begin
		wl_off = $signed({9'd0, mul_prod_s});
		if (mul_neg_s) begin
			wl_off = -wl_off;
		end
		wl_sum = $signed({4'd0, center_q, 28'd0}) + wl_off + 64'sd134217728;
		if (wl_sum[63]) begin
			wl_sat = '0;
		end else if (|wl_sum[62:60]) begin
			wl_sat = '1;
		end else begin
			wl_sat = wl_sum[59:28];
		end
	end

	logic        done_q;
	logic [31:0] wl_q;
	logic [30:0] off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= mul_vld_s;
		end
	end

	always_ff @(posedge clk) begin
		wl_q <= wl_sat;
		off_q <= mul_neg_s ? (~mul_r_s + 31'd1) : mul_r_s;
	end

	assign done = done_q;
	assign wavelength_fm = wl_q;
	assign offset_scale_units = $signed(off_q);

`ifndef SYNTHESIS
	a_offset_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(offset_scale_units) <= $signed({1'b0, clws_pkg::OFFSET_LIMIT[29:0]})
			&& $signed(offset_scale_units) >= -$signed({1'b0, clws_pkg::OFFSET_LIMIT[29:0]})))
		else $error("offset beyond limit");

	a_zero_word_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && uniform_word == 32'd0) |-> ##(clws_pkg::TOT_LAT) !done)
		else $error("zero word produced a result");

	a_word_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && uniform_word != 32'd0) |-> ##(clws_pkg::TOT_LAT) done)
		else $error("accepted word lost");
`endif

endmodule
`default_nettype wire
